// ===== hw/rtl/session_id_cam_unit_assert.svh =====
// Assertion macros shared by the session id CAM modules.
`ifndef SESSION_ID_CAM_UNIT_ASSERT_SVH
`define SESSION_ID_CAM_UNIT_ASSERT_SVH

`ifndef SYNTH

// Checks a condition at every rising edge of clk outside reset.
`define SIC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("session id cam: assertion failed");

// Checks that a trigger in one cycle is followed by a condition in the next.
`define SIC_ASSERT_NEXT(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error("session id cam: sequence assertion failed");

`else

`define SIC_ASSERT(lbl, expr)
`define SIC_ASSERT_NEXT(lbl, trig, expr)

`endif

`endif

// ===== hw/rtl/sic_pkg.sv =====
// Package with the table size, codes and transaction types of the session id CAM.
`timescale 1ns / 1ps

package sic_pkg;

  localparam int ENTRIES = 8;
  localparam int BUF_W   = 4;
  localparam int SES_W   = 16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic MODE_ALLOCATE  = 1'b0;
  localparam logic MODE_OVERWRITE = 1'b1;

  localparam logic [SES_W-1:0] MISS_SESSION = {SES_W{1'b1}};

  typedef struct packed {
    logic             op;
    logic [BUF_W-1:0] bid;
    logic [SES_W-1:0] sid;
    logic             write_mode;
  } req_t;

  typedef struct packed {
    logic [SES_W-1:0] found_session;
    logic             hit;
    logic             write_ok;
  } res_t;

endpackage

// ===== hw/rtl/session_id_cam_unit.sv =====
// Top level of the session id CAM: input register, table and result register.
`timescale 1ns / 1ps
`include "session_id_cam_unit_assert.svh"

// Session id CAM unit.
// Each input transaction is either a lookup (in_op low) or a write (in_op high)
// of a 4-bit buffer id. A lookup returns the session id of the lowest-index
// valid entry holding that buffer id, or all ones with out_hit low on a miss.
// A write in allocate mode fills the lowest free entry; in overwrite mode it
// updates the lowest valid entry with the same buffer id. out_write_ok tells
// whether the write found a place. Every input transaction yields exactly one
// result transaction, in order.
// A transaction is accepted at a rising edge where in_valid is high and
// in_stall is low, and leaves where out_valid is high and out_stall is low.
// The accepted transaction sits in the input register, the eight-way compare
// and lowest-index select run combinationally on it, and the result lands in
// the output register, while the table updates at that same edge. Throughput
// is one transaction per cycle unless the receiver stalls, set by that single
// compare and select path; a write is visible to the very next transaction.
// A synchronous reset clears all entry valid bits and both stage valids.
// When the receiver stalls, the output register holds its result, the input
// register still accepts one more transaction, and in_stall rises once both
// are full.
module session_id_cam_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [sic_pkg::BUF_W-1:0]  in_bid,
  input  logic [sic_pkg::SES_W-1:0]  in_sid,
  input  logic                       in_write_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sic_pkg::SES_W-1:0]  out_found_session,
  output logic                       out_hit,
  output logic                       out_write_ok
);

  logic          s1_valid_r;
  logic          s1_valid_nxt;
  sic_pkg::req_t s1_req_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  sic_pkg::res_t out_res_r;
  sic_pkg::res_t cam_res;
  logic          out_ready;
  logic          s1_fire;
  logic          in_take;

  // The output register can load when empty or when its result leaves now.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.op         <= in_op;
      s1_req_r.bid        <= in_bid;
      s1_req_r.sid        <= in_sid;
      s1_req_r.write_mode <= in_write_mode;
    end
    if (s1_fire) begin
      out_res_r <= cam_res;
    end
  end

  // The table commits a write only when its result moves to the output.
  sic_cam u_cam (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_fire),
    .req    (s1_req_r),
    .res    (cam_res)
  );

  assign out_valid         = out_valid_r;
  assign out_found_session = out_res_r.found_session;
  assign out_hit           = out_res_r.hit;
  assign out_write_ok      = out_res_r.write_ok;

  // A transaction leaving the input register always shows up at the output.
  `SIC_ASSERT_NEXT(a_fire_to_out, s1_fire, out_valid_r)
  // Backpressure only when both stages hold a transaction.
  `SIC_ASSERT(a_stall_full, !in_stall || (s1_valid_r && out_valid_r))

endmodule

// ===== hw/rtl/sic_cam.sv =====
// Entry storage, parallel match and lowest-index select of the session id CAM.
`timescale 1ns / 1ps
`include "session_id_cam_unit_assert.svh"

module sic_cam (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  sic_pkg::req_t req,
  output sic_pkg::res_t res
);

  logic [sic_pkg::ENTRIES-1:0] valid_r;
  logic [sic_pkg::ENTRIES-1:0] valid_nxt;
  logic [sic_pkg::BUF_W-1:0]   buf_r [sic_pkg::ENTRIES];
  logic [sic_pkg::SES_W-1:0]   ses_r [sic_pkg::ENTRIES];

  logic [sic_pkg::ENTRIES-1:0] match;
  logic [sic_pkg::ENTRIES-1:0] cand;
  logic [sic_pkg::ENTRIES-1:0] sel_m;
  logic [sic_pkg::ENTRIES-1:0] sel_w;
  logic [sic_pkg::SES_W-1:0]   found;
  logic                        do_write;

  always_comb begin
    for (int i = 0; i < sic_pkg::ENTRIES; i++) begin
      match[i] = valid_r[i] && (buf_r[i] == req.bid);
    end
    cand = (req.write_mode == sic_pkg::MODE_OVERWRITE) ? match : ~valid_r;
    // Isolate the lowest set bit of each request vector.
    sel_m = match & (~match + {{(sic_pkg::ENTRIES-1){1'b0}}, 1'b1});
    sel_w = cand & (~cand + {{(sic_pkg::ENTRIES-1){1'b0}}, 1'b1});
    found = '0;
    for (int i = 0; i < sic_pkg::ENTRIES; i++) begin
      found = found | ({sic_pkg::SES_W{sel_m[i]}} & ses_r[i]);
    end
    do_write = commit && (req.op == sic_pkg::OP_WRITE);
    valid_nxt = do_write ? (valid_r | sel_w) : valid_r;
    if (req.op == sic_pkg::OP_LOOKUP) begin
      res.found_session = (|match) ? found : sic_pkg::MISS_SESSION;
      res.hit           = |match;
      res.write_ok      = 1'b0;
    end else begin
      res.found_session = sic_pkg::MISS_SESSION;
      res.hit           = 1'b0;
      res.write_ok      = |cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sic_pkg::ENTRIES; i++) begin
      if (do_write && sel_w[i]) begin
        buf_r[i] <= req.bid;
        ses_r[i] <= req.sid;
      end
    end
  end

  // A successful allocate takes exactly one free entry.
  `SIC_ASSERT_NEXT(a_alloc_adds_one,
    do_write && res.write_ok && (req.write_mode == sic_pkg::MODE_ALLOCATE),
    $countones(valid_r) == $past($countones(valid_r)) + 1)
  // Valid bits only change on a committed write.
  `SIC_ASSERT_NEXT(a_valid_hold, !do_write, $stable(valid_r))
  // A hit needs at least one valid entry.
  `SIC_ASSERT(a_hit_needs_entry, !res.hit || (valid_r != '0))

endmodule

// ===== test/session_id_cam_unit_test.sv =====
// Self-checking testbench for the session id CAM unit with a built-in table predictor.
`timescale 1ns / 1ps

module session_id_cam_unit_test;
  import sic_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 1350;
  localparam int IDLE_PCT     = 14;
  // Accepted-transaction window in which neither side idles.
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 800;
  // The receiver holds off once, for this many cycles, after this many inputs.
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [BUF_W-1:0]  in_bid;
  logic [SES_W-1:0]  in_sid;
  logic              in_write_mode;
  logic              out_valid;
  logic              out_stall;
  logic [SES_W-1:0]  out_found_session;
  logic              out_hit;
  logic              out_write_ok;

  session_id_cam_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_bid            (in_bid),
    .in_sid            (in_sid),
    .in_write_mode     (in_write_mode),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found_session (out_found_session),
    .out_hit           (out_hit),
    .out_write_ok      (out_write_ok)
  );

  // Requests waiting to be offered, and results the table is expected to return.
  req_t req_backlog[$];
  res_t pending_results[$];

  // Shadow copy of the table, updated in acceptance order.
  bit               tbl_valid [ENTRIES];
  logic [BUF_W-1:0] tbl_buf   [ENTRIES];
  logic [SES_W-1:0] tbl_ses   [ENTRIES];

  // Buffer ids that the directed part stores, so random traffic mostly hits them.
  bit [BUF_W-1:0] seeded_ids [6] = '{4'd0, 4'd15, 4'd7, 4'd9, 4'd3, 4'd12};

  int   taken_count = 0;
  int   total_items = 0;
  int   fault_count = 0;
  int   cycle_count = 0;
  int   hold_left   = 0;
  bit   hold_done   = 0;
  bit   in_taken    = 0;
  req_t acc_req;
  res_t acc_res;
  res_t want;

  // Applies one accepted request to the shadow table and gives its result.
  // Lookups and overwrites take the lowest matching valid entry; allocates
  // take the lowest free one. Nothing changes when no entry qualifies.
  task automatic apply_to_table(input req_t r, output res_t o);
    bit take;
    bit done;
    o.found_session = MISS_SESSION;
    o.hit           = 1'b0;
    o.write_ok      = 1'b0;
    done            = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!done) begin
        if (r.op == OP_LOOKUP) begin
          if (tbl_valid[i] && tbl_buf[i] == r.bid) begin
            o.found_session = tbl_ses[i];
            o.hit           = 1'b1;
            done            = 1'b1;
          end
        end else begin
          if (r.write_mode == MODE_ALLOCATE) begin
            take = !tbl_valid[i];
          end else begin
            take = tbl_valid[i] && tbl_buf[i] == r.bid;
          end
          if (take) begin
            tbl_valid[i] = 1'b1;
            tbl_buf[i]   = r.bid;
            tbl_ses[i]   = r.sid;
            o.write_ok   = 1'b1;
            done         = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic add_req(input logic op, input logic [BUF_W-1:0] bid,
                         input logic [SES_W-1:0] sid, input logic mode);
    req_t r;
    r.op         = op;
    r.bid        = bid;
    r.sid        = sid;
    r.write_mode = mode;
    req_backlog.push_back(r);
  endtask

  task automatic note_mismatch(input string field, input logic [SES_W-1:0] exp_val,
                               input logic [SES_W-1:0] act_val);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("mismatch on %s: expected 0x%04h, got 0x%04h (result %0d)",
               field, exp_val, act_val, taken_count - pending_results.size());
    end
  endtask

  function automatic bit calm_stretch();
    return taken_count >= CALM_FROM && taken_count < CALM_TO;
  endfunction

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Every input starts at a known value; reset is released at a falling edge.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_LOOKUP;
    in_bid        = '0;
    in_sid        = '0;
    in_write_mode = MODE_ALLOCATE;
    out_stall     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_buf[i]   = '0;
      tbl_ses[i]   = '0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
  end

  // Driver: a new transaction is offered only once the last one was taken,
  // so a stalled payload never changes.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (req_backlog.size() > 0 &&
            (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
          in_op         <= req_backlog[0].op;
          in_bid        <= req_backlog[0].bid;
          in_sid        <= req_backlog[0].sid;
          in_write_mode <= req_backlog[0].write_mode;
          in_valid      <= 1'b1;
          void'(req_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, none in the calm stretch, and one long hold-off
  // that lets the table's input side fill up and stall the driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && taken_count >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm_stretch() && $urandom_range(99) < IDLE_PCT;
      end
    end
  end

  // Scoreboard: results are checked against the oldest expectation first,
  // then a newly accepted request is run through the shadow table.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("unexpected result transaction: session 0x%04h hit %0b write_ok %0b",
                     out_found_session, out_hit, out_write_ok);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_found_session !== want.found_session) begin
            note_mismatch("found_session", want.found_session, out_found_session);
          end
          if (out_hit !== want.hit) begin
            note_mismatch("hit", SES_W'(want.hit), SES_W'(out_hit));
          end
          if (out_write_ok !== want.write_ok) begin
            note_mismatch("write_ok", SES_W'(want.write_ok), SES_W'(out_write_ok));
          end
        end
      end
      if (in_valid && !in_stall) begin
        acc_req.op         = in_op;
        acc_req.bid        = in_bid;
        acc_req.sid        = in_sid;
        acc_req.write_mode = in_write_mode;
        apply_to_table(acc_req, acc_res);
        pending_results.push_back(acc_res);
        taken_count++;
      end
      in_taken <= in_valid && !in_stall;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** session_id_cam_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [BUF_W-1:0] bid;
    int               pick;

    // Empty table: lookups miss at both id extremes and an overwrite fails.
    add_req(OP_LOOKUP, 4'd0,  16'h0000, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd15, 16'hFFFF, MODE_OVERWRITE);
    add_req(OP_WRITE,  4'd3,  16'h3333, MODE_OVERWRITE);
    // First entries, with the session id extremes.
    add_req(OP_WRITE,  4'd0,  16'h0000, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd15, 16'hFFFF, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd0,  16'h0000, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd15, 16'h0000, MODE_ALLOCATE);
    // A duplicate id: the lower entry wins for lookups and overwrites.
    add_req(OP_WRITE,  4'd15, 16'h1234, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd15, 16'h0000, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd15, 16'hABCD, MODE_OVERWRITE);
    add_req(OP_LOOKUP, 4'd15, 16'h0000, MODE_ALLOCATE);
    // Overwrite of an id that is not stored changes nothing.
    add_req(OP_WRITE,  4'd7,  16'h7070, MODE_OVERWRITE);
    // Fill the table, another duplicate included.
    add_req(OP_WRITE,  4'd7,  16'h5A5A, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd9,  16'hA5A5, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd3,  16'h0F0F, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd12, 16'hF0F0, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd7,  16'h7777, MODE_ALLOCATE);
    // Full table: an allocate fails and its id stays absent.
    add_req(OP_WRITE,  4'd5,  16'h1111, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd5,  16'h0000, MODE_ALLOCATE);
    add_req(OP_LOOKUP, 4'd7,  16'h0000, MODE_ALLOCATE);
    add_req(OP_WRITE,  4'd7,  16'h0001, MODE_OVERWRITE);
    // Session and mode fields are ignored on a lookup.
    add_req(OP_LOOKUP, 4'd7,  16'hFFFF, MODE_OVERWRITE);
    add_req(OP_WRITE,  4'd0,  16'h8000, MODE_OVERWRITE);

    // Random traffic: mostly lookups and overwrites of stored ids.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(99) < 70) begin
        pick = $urandom_range(5);
        bid  = seeded_ids[pick];
      end else begin
        bid = BUF_W'($urandom_range(15));
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        add_req(OP_LOOKUP, bid, SES_W'($urandom), 1'($urandom));
      end else if (pick < 85) begin
        add_req(OP_WRITE, bid, SES_W'($urandom), MODE_OVERWRITE);
      end else begin
        add_req(OP_WRITE, bid, SES_W'($urandom), MODE_ALLOCATE);
      end
    end
    total_items = req_backlog.size();

    @(posedge rst_n);
    while (taken_count < total_items || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("** session_id_cam_unit: PASSED **");
    end else begin
      $display("** session_id_cam_unit: FAILED **");
    end
    $finish;
  end

endmodule
